### src/sti_pkg.sv
`default_nettype none
package sti_pkg;

    localparam int COORD_BITS      = 16;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int POINT_BITS      = 3 * COORD_BITS;
    localparam int DIFF_BITS       = COORD_BITS + 1;
    localparam int PROD_BITS       = 2 * DIFF_BITS;
    localparam int CROSS_BITS      = PROD_BITS + 1;
    localparam int DPROD_BITS      = DIFF_BITS + CROSS_BITS;
    localparam int DOT_BITS        = DPROD_BITS + 2;
    localparam int THR_BITS        = 41;
    localparam int TOL_BITS        = 13;
    localparam int CFG_DATA_BITS   = 41;
    localparam int T_BITS          = PARAM_FRAC_BITS + 1;
    localparam int LOW_BITS        = DOT_BITS + TOL_BITS;
    localparam int CMP_BITS        = DOT_BITS + PARAM_FRAC_BITS + 2;
    localparam int DIV_STAGES      = PARAM_FRAC_BITS + 1;

    typedef enum logic [0:0] {
        CFG_DET_THRESHOLD = 1'b0,
        CFG_PARAM_TOL     = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        REASON_HIT      = 3'd0,
        REASON_DEGEN    = 3'd1,
        REASON_U_OUT    = 3'd2,
        REASON_V_OUT    = 3'd3,
        REASON_T_OUT    = 3'd4
    } t_reason;

    typedef enum logic [1:0] {
        T_ZERO = 2'd0,
        T_ONE  = 2'd1,
        T_DIV  = 2'd2
    } t_tmode;

    typedef struct packed {
        logic                        dir_zero;
        logic signed [DOT_BITS-1:0]  det;
        logic signed [DOT_BITS-1:0]  nu;
        logic signed [DOT_BITS-1:0]  nv;
        logic signed [DOT_BITS-1:0]  nt;
    } t_geom;

    typedef struct packed {
        t_reason               reason;
        t_tmode                mode;
        logic [DOT_BITS-1:0]   rem;
        logic [DOT_BITS-1:0]   den;
    } t_div_item;

    function automatic logic signed [COORD_BITS-1:0] coord(
        input logic [POINT_BITS-1:0] p, input int k);
        return p[k*COORD_BITS +: COORD_BITS];
    endfunction

endpackage
`default_nettype wire

### src/sti_geom.sv
`default_nettype none
module sti_geom (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [sti_pkg::POINT_BITS-1:0] i_p0,
    input  wire logic [sti_pkg::POINT_BITS-1:0] i_p1,
    input  wire logic [sti_pkg::POINT_BITS-1:0] i_a,
    input  wire logic [sti_pkg::POINT_BITS-1:0] i_b,
    input  wire logic [sti_pkg::POINT_BITS-1:0] i_c,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output sti_pkg::t_geom                      o_geom
);
    import sti_pkg::*;

    localparam int NST = 5;

    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    logic signed [DIFF_BITS-1:0]  r1_dir [3], r1_e1 [3], r1_e2 [3], r1_s [3];
    logic                         r1_dz;
    logic signed [DIFF_BITS-1:0]  r2_dir [3], r2_e1 [3], r2_e2 [3], r2_s [3];
    logic                         r2_dz;
    logic signed [PROD_BITS-1:0]  r2_pa [3], r2_pb [3], r2_qa [3], r2_qb [3];
    logic signed [DIFF_BITS-1:0]  r3_dir [3], r3_e1 [3], r3_e2 [3], r3_s [3];
    logic                         r3_dz;
    logic signed [CROSS_BITS-1:0] r3_p [3], r3_q [3];
    logic                         r4_dz;
    logic signed [DPROD_BITS-1:0] r4_det [3], r4_nu [3], r4_nv [3], r4_nt [3];
    t_geom                        r5_g;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];
    assign o_geom  = r5_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    // differences
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r1_dir[i] <= DIFF_BITS'(coord(i_p1, i)) - DIFF_BITS'(coord(i_p0, i));
                r1_e1[i]  <= DIFF_BITS'(coord(i_b, i)) - DIFF_BITS'(coord(i_a, i));
                r1_e2[i]  <= DIFF_BITS'(coord(i_c, i)) - DIFF_BITS'(coord(i_a, i));
                r1_s[i]   <= DIFF_BITS'(coord(i_p0, i)) - DIFF_BITS'(coord(i_a, i));
            end
            r1_dz <= (i_p0 == i_p1);
        end
    end

    // cross product partial terms: p = dir x e2, q = s x e1
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r2_pa[i] <= r1_dir[(i+1)%3] * r1_e2[(i+2)%3];
                r2_pb[i] <= r1_dir[(i+2)%3] * r1_e2[(i+1)%3];
                r2_qa[i] <= r1_s[(i+1)%3] * r1_e1[(i+2)%3];
                r2_qb[i] <= r1_s[(i+2)%3] * r1_e1[(i+1)%3];
            end
            r2_dir <= r1_dir;
            r2_e1  <= r1_e1;
            r2_e2  <= r1_e2;
            r2_s   <= r1_s;
            r2_dz  <= r1_dz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r3_p[i] <= CROSS_BITS'(r2_pa[i]) - CROSS_BITS'(r2_pb[i]);
                r3_q[i] <= CROSS_BITS'(r2_qa[i]) - CROSS_BITS'(r2_qb[i]);
            end
            r3_dir <= r2_dir;
            r3_e1  <= r2_e1;
            r3_e2  <= r2_e2;
            r3_s   <= r2_s;
            r3_dz  <= r2_dz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                r4_det[i] <= r3_e1[i] * r3_p[i];
                r4_nu[i]  <= r3_s[i] * r3_p[i];
                r4_nv[i]  <= r3_dir[i] * r3_q[i];
                r4_nt[i]  <= r3_e2[i] * r3_q[i];
            end
            r4_dz <= r3_dz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_g.dir_zero <= r4_dz;
            r5_g.det <= DOT_BITS'(r4_det[0]) + DOT_BITS'(r4_det[1]) + DOT_BITS'(r4_det[2]);
            r5_g.nu  <= DOT_BITS'(r4_nu[0]) + DOT_BITS'(r4_nu[1]) + DOT_BITS'(r4_nu[2]);
            r5_g.nv  <= DOT_BITS'(r4_nv[0]) + DOT_BITS'(r4_nv[1]) + DOT_BITS'(r4_nv[2]);
            r5_g.nt  <= DOT_BITS'(r4_nt[0]) + DOT_BITS'(r4_nt[1]) + DOT_BITS'(r4_nt[2]);
        end
    end

endmodule
`default_nettype wire

### src/sti_classify.sv
`default_nettype none
module sti_classify (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [sti_pkg::THR_BITS-1:0] i_thr,
    input  wire logic [sti_pkg::TOL_BITS-1:0] i_tol,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire sti_pkg::t_geom               i_geom,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output sti_pkg::t_div_item                o_item
);
    import sti_pkg::*;

    localparam int NST = 3;

    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    logic                       r1_degen;
    logic [DOT_BITS-1:0]        r1_abs;
    logic signed [DOT_BITS-1:0] r1_nu, r1_nv, r1_nt;
    logic                       r2_degen;
    logic [DOT_BITS-1:0]        r2_abs;
    logic signed [DOT_BITS-1:0] r2_nu, r2_nv, r2_nt;
    logic [LOW_BITS-1:0]        r2_low;
    t_div_item                  r3_item;

    logic [DOT_BITS-1:0]        abs_det;
    logic signed [CMP_BITS-1:0] low_s, high_s, nu_s, nv_s, nt_s, sum_s;
    logic                       u_out, v_out, t_out;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];
    assign o_item  = r3_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    assign abs_det = i_geom.det[DOT_BITS-1] ? DOT_BITS'(-i_geom.det) : DOT_BITS'(i_geom.det);

    // fold the sign of det into the numerators
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_degen <= i_geom.dir_zero || (i_geom.det == '0) ||
                        (abs_det < DOT_BITS'(i_thr));
            r1_abs   <= abs_det;
            r1_nu    <= i_geom.det[DOT_BITS-1] ? -i_geom.nu : i_geom.nu;
            r1_nv    <= i_geom.det[DOT_BITS-1] ? -i_geom.nv : i_geom.nv;
            r1_nt    <= i_geom.det[DOT_BITS-1] ? -i_geom.nt : i_geom.nt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_low   <= LOW_BITS'(r1_abs) * LOW_BITS'(i_tol);
            r2_degen <= r1_degen;
            r2_abs   <= r1_abs;
            r2_nu    <= r1_nu;
            r2_nv    <= r1_nv;
            r2_nt    <= r1_nt;
        end
    end

    // range checks scaled by det, no division
    always_comb begin
        low_s  = -$signed(CMP_BITS'(r2_low));
        high_s = $signed(CMP_BITS'({r2_abs, {PARAM_FRAC_BITS{1'b0}}}))
               + $signed(CMP_BITS'(r2_low));
        nu_s   = CMP_BITS'(r2_nu) <<< PARAM_FRAC_BITS;
        nv_s   = CMP_BITS'(r2_nv) <<< PARAM_FRAC_BITS;
        nt_s   = CMP_BITS'(r2_nt) <<< PARAM_FRAC_BITS;
        sum_s  = (CMP_BITS'(r2_nu) + CMP_BITS'(r2_nv)) <<< PARAM_FRAC_BITS;
        u_out  = (nu_s < low_s) || (nu_s > high_s);
        v_out  = (nv_s < low_s) || (sum_s > high_s);
        t_out  = (nt_s < low_s) || (nt_s > high_s);
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            if (r2_degen) begin
                r3_item.reason <= REASON_DEGEN;
            end else if (u_out) begin
                r3_item.reason <= REASON_U_OUT;
            end else if (v_out) begin
                r3_item.reason <= REASON_V_OUT;
            end else if (t_out) begin
                r3_item.reason <= REASON_T_OUT;
            end else begin
                r3_item.reason <= REASON_HIT;
            end
            if (r2_nt[DOT_BITS-1] || (r2_nt == '0)) begin
                r3_item.mode <= T_ZERO;
            end else if (DOT_BITS'(r2_nt) >= r2_abs) begin
                r3_item.mode <= T_ONE;
            end else begin
                r3_item.mode <= T_DIV;
            end
            r3_item.rem <= DOT_BITS'(r2_nt);
            r3_item.den <= r2_abs;
        end
    end

endmodule
`default_nettype wire

### src/sti_divide.sv
`default_nettype none
module sti_divide (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire sti_pkg::t_div_item        i_item,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic                           o_hit,
    output logic [sti_pkg::T_BITS-1:0]     o_t_hit,
    output logic [2:0]                     o_miss_reason
);
    import sti_pkg::*;

    localparam int NST = DIV_STAGES + 1;

    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    t_div_item         r_item [DIV_STAGES];
    logic [T_BITS-1:0] r_q    [DIV_STAGES];
    t_div_item         step_in  [DIV_STAGES];
    t_div_item         n_item   [DIV_STAGES];
    logic [T_BITS-1:0] q_in     [DIV_STAGES];
    logic [DOT_BITS:0] shifted  [DIV_STAGES];
    logic              take     [DIV_STAGES];

    logic              r_hit;
    logic [T_BITS-1:0] r_t;
    t_reason           r_reason;
    logic [T_BITS:0]   rounded;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    // one quotient bit per stage, restoring
    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            step_in[k] = (k == 0) ? i_item : r_item[k-1];
            q_in[k]    = (k == 0) ? '0 : r_q[k-1];
            shifted[k] = {step_in[k].rem, 1'b0};
            take[k]    = shifted[k] >= {1'b0, step_in[k].den};
            n_item[k]     = step_in[k];
            n_item[k].rem = take[k] ? DOT_BITS'(shifted[k] - {1'b0, step_in[k].den})
                                    : DOT_BITS'(shifted[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (en[k]) begin
                r_item[k] <= n_item[k];
                r_q[k]    <= {q_in[k][T_BITS-2:0], take[k]};
            end
        end
    end

    assign rounded = ({1'b0, r_q[DIV_STAGES-1]} + (T_BITS+1)'(1)) >> 1;

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) begin
            r_reason <= r_item[DIV_STAGES-1].reason;
            r_hit    <= (r_item[DIV_STAGES-1].reason == REASON_HIT);
            if (r_item[DIV_STAGES-1].reason != REASON_HIT) begin
                r_t <= '0;
            end else begin
                case (r_item[DIV_STAGES-1].mode)
                    T_ONE:   r_t <= T_BITS'(1) << PARAM_FRAC_BITS;
                    T_DIV:   r_t <= T_BITS'(rounded);
                    default: r_t <= '0;
                endcase
            end
        end
    end

    assign o_hit         = r_hit;
    assign o_t_hit       = r_t;
    assign o_miss_reason = r_reason;

endmodule
`default_nettype wire

### src/segment_triangle_intersect.sv
`default_nettype none
// channel   valid          ready          payload
// input     i_in_valid     o_in_ready     i_seg_start, i_seg_end, i_corner_a/b/c
// output    o_out_valid    i_out_ready    o_hit, o_t_hit, o_miss_reason
// config    i_cfg_we       (none)         i_cfg_index, i_cfg_data
//
// one word per cycle while the output is not stalled; 5 geometry stages, 3 classify
// stages, 17 divider stages (one quotient bit each) and the output register
// reset clears valid bits and loads det_threshold 1, param_tolerance 0
// each full stage holds while its successor cannot advance, so gaps close under a stall
module segment_triangle_intersect (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [sti_pkg::POINT_BITS-1:0]    i_seg_start,
    input  wire logic [sti_pkg::POINT_BITS-1:0]    i_seg_end,
    input  wire logic [sti_pkg::POINT_BITS-1:0]    i_corner_a,
    input  wire logic [sti_pkg::POINT_BITS-1:0]    i_corner_b,
    input  wire logic [sti_pkg::POINT_BITS-1:0]    i_corner_c,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_hit,
    output logic [sti_pkg::T_BITS-1:0]             o_t_hit,
    output logic [2:0]                             o_miss_reason,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_index,
    input  wire logic [sti_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import sti_pkg::*;

    logic [THR_BITS-1:0] r_thr;
    logic [TOL_BITS-1:0] r_tol;

    logic      g_valid, g_ready, c_valid, c_ready;
    t_geom     geom;
    t_div_item item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_BITS'(1);
            r_tol <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DET_THRESHOLD: r_thr <= THR_BITS'(i_cfg_data);
                CFG_PARAM_TOL:     r_tol <= TOL_BITS'(i_cfg_data);
                default: ;
            endcase
        end
    end

    sti_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_p0    (i_seg_start),
        .i_p1    (i_seg_end),
        .i_a     (i_corner_a),
        .i_b     (i_corner_b),
        .i_c     (i_corner_c),
        .o_valid (g_valid),
        .i_ready (g_ready),
        .o_geom  (geom)
    );

    sti_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_thr   (r_thr),
        .i_tol   (r_tol),
        .i_valid (g_valid),
        .o_ready (g_ready),
        .i_geom  (geom),
        .o_valid (c_valid),
        .i_ready (c_ready),
        .o_item  (item)
    );

    sti_divide u_divide (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (c_valid),
        .o_ready       (c_ready),
        .i_item        (item),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_hit         (o_hit),
        .o_t_hit       (o_t_hit),
        .o_miss_reason (o_miss_reason)
    );

endmodule
`default_nettype wire

### tb/segment_triangle_intersect_tb.sv
`default_nettype none
module segment_triangle_intersect_tb;
    import sti_pkg::*;

    localparam int LATENCY     = 26;
    localparam int STALL_LIMIT = 20000;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic          hit;
        logic [16:0]   t_hit;
        t_reason       reason;
    } t_verdict;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [POINT_BITS-1:0]    i_seg_start, i_seg_end, i_corner_a, i_corner_b, i_corner_c;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic                     o_hit;
    logic [T_BITS-1:0]        o_t_hit;
    logic [2:0]               o_miss_reason;
    logic                     i_cfg_we;
    logic                     i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    logic [40:0] thr_shadow;
    logic [12:0] tol_shadow;
    t_verdict    expected_verdicts[$];
    int          mismatches;
    int          idle_cycles;
    bit          rx_long_stalls;
    bit          tx_gaps;

    segment_triangle_intersect u_top (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready,
        .i_seg_start, .i_seg_end, .i_corner_a, .i_corner_b, .i_corner_c,
        .o_out_valid, .i_out_ready, .o_hit, .o_t_hit, .o_miss_reason,
        .i_cfg_we, .i_cfg_index, .i_cfg_data
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_wide coord_of(logic [47:0] p, int k);
        logic signed [15:0] c;
        c = p[k*16 +: 16];
        return t_wide'(c);
    endfunction

    function automatic t_verdict crossing_verdict(logic [47:0] p0, logic [47:0] p1,
                                                  logic [47:0] a, logic [47:0] b,
                                                  logic [47:0] c);
        t_wide    dir[3], e1[3], e2[3], s[3], pv[3], qv[3];
        t_wide    det, adet, nu, nv, nt, lowb, highb, r;
        t_verdict v;
        logic [17:0] q;
        v = '{hit: 1'b0, t_hit: '0, reason: REASON_HIT};
        for (int i = 0; i < 3; i++) begin
            dir[i] = coord_of(p1, i) - coord_of(p0, i);
            e1[i]  = coord_of(b, i) - coord_of(a, i);
            e2[i]  = coord_of(c, i) - coord_of(a, i);
            s[i]   = coord_of(p0, i) - coord_of(a, i);
        end
        pv[0] = dir[1]*e2[2] - dir[2]*e2[1];
        pv[1] = dir[2]*e2[0] - dir[0]*e2[2];
        pv[2] = dir[0]*e2[1] - dir[1]*e2[0];
        det  = e1[0]*pv[0] + e1[1]*pv[1] + e1[2]*pv[2];
        adet = det < 0 ? -det : det;
        if ((dir[0] == 0 && dir[1] == 0 && dir[2] == 0) || det == 0
                || adet < t_wide'(thr_shadow)) begin
            v.reason = REASON_DEGEN;
            return v;
        end
        qv[0] = s[1]*e1[2] - s[2]*e1[1];
        qv[1] = s[2]*e1[0] - s[0]*e1[2];
        qv[2] = s[0]*e1[1] - s[1]*e1[0];
        nu = s[0]*pv[0] + s[1]*pv[1] + s[2]*pv[2];
        nv = dir[0]*qv[0] + dir[1]*qv[1] + dir[2]*qv[2];
        nt = e2[0]*qv[0] + e2[1]*qv[1] + e2[2]*qv[2];
        if (det < 0) begin
            nu = -nu; nv = -nv; nt = -nt;
        end
        lowb  = -(adet * t_wide'(tol_shadow));
        highb = adet * (t_wide'(65536) + t_wide'(tol_shadow));
        if ((nu <<< 16) < lowb || (nu <<< 16) > highb)
            v.reason = REASON_U_OUT;
        else if ((nv <<< 16) < lowb || ((nu + nv) <<< 16) > highb)
            v.reason = REASON_V_OUT;
        else if ((nt <<< 16) < lowb || (nt <<< 16) > highb)
            v.reason = REASON_T_OUT;
        if (v.reason != REASON_HIT)
            return v;
        v.hit = 1'b1;
        if (nt <= 0) begin
            v.t_hit = '0;
        end else if (nt >= adet) begin
            v.t_hit = 17'h10000;
        end else begin
            r = nt;
            q = '0;
            for (int i = 0; i <= 16; i++) begin
                r = r <<< 1;
                q = q << 1;
                if (r >= adet) begin
                    r = r - adet;
                    q[0] = 1'b1;
                end
            end
            v.t_hit = 17'((q + 1) >> 1);
        end
        return v;
    endfunction

    function automatic logic [47:0] pack_point(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    task automatic write_reg(t_cfg_index idx, logic [40:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_DET_THRESHOLD) thr_shadow = value;
        else tol_shadow = value[12:0];
    endtask

    task automatic drain();
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_word(logic [47:0] p0, logic [47:0] p1,
                             logic [47:0] a, logic [47:0] b, logic [47:0] c);
        int gap;
        if (tx_gaps) begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0) gap = 0;
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_seg_start <= p0;
        i_seg_end   <= p1;
        i_corner_a  <= a;
        i_corner_b  <= b;
        i_corner_c  <= c;
        expected_verdicts = {expected_verdicts, crossing_verdict(p0, p1, a, b, c)};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // triangle mostly in z=0 plane; segments crossing, missing or touching it, plus degenerate and full-range words
    task automatic test_directed();
        logic [47:0] a, b, c;
        a = pack_point(0, 0, 0);
        b = pack_point(4096, 0, 0);
        c = pack_point(0, 4096, 0);
        tx_gaps = 1'b0;
        send_word(pack_point(1000, 1000, -4096), pack_point(1000, 1000, 4096), a, b, c);
        send_word(pack_point(1000, 1000, 0), pack_point(1000, 1000, 4096), a, b, c);
        send_word(pack_point(1000, 1000, -4096), pack_point(1000, 1000, 0), a, b, c);
        send_word(pack_point(1000, 1000, 5), pack_point(1000, 1000, 5), a, b, c);
        send_word(pack_point(0, 0, -4096), pack_point(4096, 0, -4096), a, b, c);
        send_word(pack_point(-500, 1000, -4096), pack_point(-500, 1000, 4096), a, b, c);
        send_word(pack_point(1000, -500, -4096), pack_point(1000, -500, 4096), a, b, c);
        send_word(pack_point(3000, 3000, -4096), pack_point(3000, 3000, 4096), a, b, c);
        send_word(pack_point(1000, 1000, 100), pack_point(1000, 1000, 4096), a, b, c);
        send_word(pack_point(1000, 1000, -4096), pack_point(1000, 1000, -100), a, b, c);
        send_word(pack_point(0, 0, -4096), pack_point(0, 0, 4096), a, b, c);
        send_word(pack_point(4096, 0, -1), pack_point(4096, 0, 3), a, b, c);
        send_word(pack_point(1000, 1000, 4096), pack_point(1000, 1000, -4096), c, b, a);
        send_word(48'h8000_8000_8000, 48'h7fff_7fff_7fff, 48'h8000_7fff_8000,
                  48'h7fff_8000_7fff, 48'h0000_7fff_8000);
        send_word(48'hffff_ffff_ffff, 48'h0, 48'h7fff_7fff_7fff,
                  48'h8000_8000_8000, 48'h7fff_0000_8000);
        send_word(48'h0, 48'h0, 48'h0, 48'h0, 48'h0);
        end_burst();
        drain();
    endtask

    task automatic send_random(int count);
        logic [47:0] p0, p1, a, b, c;
        int span;
        for (int n = 0; n < count; n++) begin
            span = ($urandom_range(0, 3) == 0) ? 32767 : 6000;
            a = pack_point($urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span,
                           $urandom_range(0, 2*span) - span);
            b = pack_point($urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span,
                           $urandom_range(0, 2*span) - span);
            c = pack_point($urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span,
                           $urandom_range(0, 2*span) - span);
            if ($urandom_range(0, 9) < 6) begin
                // aim the segment through a point near the triangle
                int w0, w1, cx, cy, cz, dx, dy, dz, i0, i1;
                w0 = $urandom_range(0, 1100) - 50;
                w1 = $urandom_range(0, 1100 - (w0 > 0 ? w0 : 0)) - 50;
                cx = int'(coord_of(a,0) + (w0*(coord_of(b,0)-coord_of(a,0))
                     + w1*(coord_of(c,0)-coord_of(a,0)))/1000);
                cy = int'(coord_of(a,1) + (w0*(coord_of(b,1)-coord_of(a,1))
                     + w1*(coord_of(c,1)-coord_of(a,1)))/1000);
                cz = int'(coord_of(a,2) + (w0*(coord_of(b,2)-coord_of(a,2))
                     + w1*(coord_of(c,2)-coord_of(a,2)))/1000);
                dx = $urandom_range(0, 8000) - 4000;
                dy = $urandom_range(0, 8000) - 4000;
                dz = $urandom_range(0, 8000) - 4000;
                i0 = $urandom_range(0, 1200) - 100;
                i1 = $urandom_range(0, 1200) - 100;
                p0 = pack_point(cx - dx*i0/1000, cy - dy*i0/1000, cz - dz*i0/1000);
                p1 = pack_point(cx + dx*i1/1000, cy + dy*i1/1000, cz + dz*i1/1000);
            end else begin
                p0 = 48'({$urandom, $urandom});
                p1 = ($urandom_range(0, 15) == 0) ? p0 : 48'({$urandom, $urandom});
                if ($urandom_range(0, 7) == 0) a = 48'({$urandom, $urandom});
            end
            send_word(p0, p1, a, b, c);
        end
        end_burst();
    endtask

    task automatic test_reset_settings();
        tx_gaps = 1'b1;
        send_random(250);
        // sender holds off until the pipe is empty
        drain();
        send_random(50);
        drain();
    endtask

    task automatic test_tolerance_sweep();
        write_reg(CFG_PARAM_TOL, 41'd4096);
        send_random(200);
        drain();
        write_reg(CFG_PARAM_TOL, 41'h1fff_ffff);
        send_random(100);
        drain();
        write_reg(CFG_PARAM_TOL, 41'd300);
        send_random(150);
        drain();
    endtask

    task automatic test_threshold_sweep();
        write_reg(CFG_DET_THRESHOLD, 41'd0);
        write_reg(CFG_PARAM_TOL, 41'd0);
        send_random(150);
        drain();
        write_reg(CFG_DET_THRESHOLD, 41'd1 << 38);
        send_random(100);
        drain();
        write_reg(CFG_DET_THRESHOLD, 41'h1ff_ffff_ffff);
        send_random(50);
        drain();
        write_reg(CFG_DET_THRESHOLD, 41'd1 << 40);
        write_reg(CFG_PARAM_TOL, 41'd8191);
        send_random(50);
        drain();
        write_reg(CFG_DET_THRESHOLD, 41'd1);
        write_reg(CFG_PARAM_TOL, 41'd0);
        rx_long_stalls = 1'b0;
        tx_gaps = 1'b0;
        send_random(100);
        drain();
    endtask

    // result side: random back-pressure and comparison against the queue
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: hit=%0d t=%0d reason=%0d",
                                 o_hit, o_t_hit, o_miss_reason);
                end else begin
                    exp_v = expected_verdicts.pop_front();
                    if (o_hit !== exp_v.hit || o_t_hit !== exp_v.t_hit
                            || o_miss_reason !== exp_v.reason) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp hit=%0d t=%0d reason=%0d, got %0d %0d %0d",
                                     exp_v.hit, exp_v.t_hit, exp_v.reason,
                                     o_hit, o_t_hit, o_miss_reason);
                    end
                end
            end
            if (!rx_long_stalls)
                i_out_ready <= ($urandom_range(0, 3) != 0);
            else if ($urandom_range(0, 49) == 0)
                i_out_ready <= 1'b0;
            else if (!i_out_ready && $urandom_range(0, 2) != 0 && $urandom_range(0, 9) != 0)
                i_out_ready <= 1'b1;
            else
                i_out_ready <= ($urandom_range(0, 4) != 0) || $urandom_range(0, 1) == 0;
        end
    end

    // watchdog on progress
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("segment_triangle_intersect_tb failed");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_seg_start    = '0;
        i_seg_end      = '0;
        i_corner_a     = '0;
        i_corner_b     = '0;
        i_corner_c     = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = 1'b0;
        i_cfg_data     = '0;
        thr_shadow     = 41'd1;
        tol_shadow     = '0;
        mismatches     = 0;
        idle_cycles    = 0;
        rx_long_stalls = 1'b1;
        tx_gaps        = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_reset_settings();
        test_tolerance_sweep();
        test_threshold_sweep();
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("segment_triangle_intersect_tb passed");
        else
            $display("segment_triangle_intersect_tb failed");
        $finish;
    end

endmodule
`default_nettype wire
